// File: rtl/wspd_pkg.sv
package wspd_pkg;

  localparam int DataW    = 16;
  localparam int BitsW    = 52;
  localparam int CntW     = 7;
  localparam int CfgAddrW = 2;
  localparam int NibCnt   = 13;

  // burst queue between front and back
  localparam int QDepth = 2;
  localparam int QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [DataW-1:0] SpaceMinRst  = 16'd1100;
  localparam logic [DataW-1:0] SpaceMaxRst  = 16'd1400;
  localparam logic [DataW-1:0] MarkSplitRst = 16'd1000;

  // pair count seen before the last pair
  localparam logic [CntW-1:0] CntLen52 = 7'd51;
  localparam logic [CntW-1:0] CntLen51 = 7'd50;
  localparam logic [CntW-1:0] CntSat   = 7'd127;

  localparam logic [3:0] SyncNib  = 4'h0;
  localparam logic [3:0] Pre9     = 4'h9;
  localparam logic [3:0] Pre6     = 4'h6;
  localparam logic [3:0] KindMask = 4'hB;
  localparam logic [3:0] KTemp    = 4'h0;
  localparam logic [3:0] KHum     = 4'h1;
  localparam logic [3:0] KRain    = 4'h2;
  localparam logic [3:0] KSpeed   = 4'h3;
  localparam logic [3:0] KGust    = 4'hB;

  localparam logic [11:0] TempOff9 = 12'd300;
  localparam logic [11:0] TempOff6 = 12'd400;
  localparam logic [13:0] WindMul  = 14'd36;

  // reciprocal constants, exact for values below 2**14
  localparam int          RecipShift = 19;
  localparam int          RecipW     = 30;
  localparam logic [15:0] Recip10    = 16'd52429;
  localparam logic [15:0] Recip100   = 16'd5243;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SPACE_MIN  = 2'd0,
    REG_SPACE_MAX  = 2'd1,
    REG_MARK_SPLIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COUNT    = 3'd1,
    ST_TIMING   = 3'd2,
    ST_HEADER   = 3'd3,
    ST_SYNC     = 3'd4,
    ST_PREAMBLE = 3'd5,
    ST_CHECKSUM = 3'd6,
    ST_HUMIDITY = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    KIND_TEMP    = 3'd0,
    KIND_HUM     = 3'd1,
    KIND_RAIN    = 3'd2,
    KIND_SPEED   = 3'd3,
    KIND_GUST    = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    DIV_ONE     = 2'd0,
    DIV_TEN     = 2'd1,
    DIV_HUNDRED = 2'd2
  } wdiv_t;

  typedef struct packed {
    logic [BitsW-1:0] bits;
    logic             len_ok;
    logic             len51;
    logic             timing_err;
  } burst_t;

endpackage

// File: rtl/wspd_front.sv
module wspd_front
  import wspd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [DataW-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [DataW-1:0]    in_mark_time,
  input  logic [DataW-1:0]    in_space_time,
  input  logic                in_last_pair,
  input  logic                q_full,
  output logic                push,
  output burst_t              push_data
);

  logic [DataW-1:0] space_min_r, space_max_r, mark_split_r;
  logic [BitsW-1:0] shift_r, shift_nxt;
  logic [CntW-1:0]  cnt_r;
  logic             terr_r;
  logic             bit_in, space_bad, accept;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign bit_in    = (in_mark_time <= mark_split_r);
  assign space_bad = (in_space_time < space_min_r) || (in_space_time > space_max_r);
  assign shift_nxt = {shift_r[BitsW-2:0], bit_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_min_r  <= SpaceMinRst;
      space_max_r  <= SpaceMaxRst;
      mark_split_r <= MarkSplitRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SPACE_MIN:  space_min_r  <= cfg_wdata;
        REG_SPACE_MAX:  space_max_r  <= cfg_wdata;
        REG_MARK_SPLIT: mark_split_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      cnt_r   <= '0;
      terr_r  <= 1'b0;
    end else if (accept) begin
      if (in_last_pair) begin
        shift_r <= '0;
        cnt_r   <= '0;
        terr_r  <= 1'b0;
      end else begin
        shift_r <= shift_nxt;
        terr_r  <= terr_r | space_bad;
        if (cnt_r != CntSat) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // the last pair's space is not checked
  assign push                 = accept && in_last_pair;
  assign push_data.bits       = shift_nxt;
  assign push_data.len_ok     = (cnt_r == CntLen52) || (cnt_r == CntLen51);
  assign push_data.len51      = (cnt_r == CntLen51);
  assign push_data.timing_err = terr_r;

endmodule

// File: rtl/wspd_queue.sv
module wspd_queue
  import wspd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  burst_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   nonempty,
  output burst_t head
);

  burst_t           mem_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == QCntW'(QDepth));
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  function automatic logic [QAw-1:0] ptr_inc(input logic [QAw-1:0] p);
    ptr_inc = (p == QAw'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// File: rtl/wspd_back.sv
module wspd_back
  import wspd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  burst_t             q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [2:0]         out_reading_kind,
  output logic               out_model_b,
  output logic [7:0]         out_sensor_id,
  output logic signed [11:0] out_temperature,
  output logic [7:0]         out_humidity_pct,
  output logic [11:0]        out_rain_count,
  output logic [3:0]         out_wind_direction,
  output logic [13:0]        out_wind_value,
  output logic [23:0]        out_signature
);

  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic        model_b;
    logic [7:0]  sensor_id;
    logic [11:0] temperature;
    logic [7:0]  humidity;
    logic [11:0] rain;
    logic [3:0]  direction;
    logic [13:0] prod;
    wdiv_t       div;
    logic [23:0] signature;
  } dec_t;

  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic        model_b;
    logic [7:0]  sensor_id;
    logic [11:0] temperature;
    logic [7:0]  humidity;
    logic [11:0] rain;
    logic [3:0]  direction;
    logic [13:0] wind;
    logic [23:0] signature;
  } res_t;

  logic             en;
  logic             s1_v_r, out_v_r;
  dec_t             s1_r, s1_nxt;
  res_t             out_r, out_nxt;
  logic [BitsW-1:0] bits;
  logic [3:0]       nib [NibCnt];
  logic [3:0]       sum_a, sum_b, csum, masked;
  logic [19:0]      first20;
  logic [7:0]       raw;
  logic [10:0]      dsum;
  logic             model9;
  logic [RecipW-1:0] q10, q100;

  assign en    = !out_v_r || !out_stall;
  assign q_pop = en && q_nonempty;

  // stage 1: checks and nibble fields
  assign bits = q_head.len51 ? {q_head.bits[BitsW-2:0], 1'b0} : q_head.bits;

  always_comb begin
    for (int i = 0; i < NibCnt; i++) begin
      nib[i] = bits[BitsW-1-4*i -: 4];
    end
  end

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int i = 0; i < 6; i++) begin
      sum_a = sum_a + nib[i];
      sum_b = sum_b + nib[i+6];
    end
    csum = sum_a + sum_b;
  end

  assign first20 = bits[BitsW-1 -: 20];
  assign masked  = nib[2] & KindMask;
  assign raw     = {nib[7], nib[8]};
  assign model9  = (nib[1] == Pre9);
  assign dsum    = 11'(nib[7]) * 11'd100 + 11'(nib[8]) * 11'd10 + 11'(nib[9]);

  always_comb begin
    s1_nxt = '0;
    priority if (!q_head.len_ok) begin
      s1_nxt.status = ST_COUNT;
    end else if (q_head.timing_err) begin
      s1_nxt.status = ST_TIMING;
    end else if (first20 == '0) begin
      s1_nxt.status = ST_HEADER;
    end else if (nib[0] != SyncNib) begin
      s1_nxt.status = ST_SYNC;
    end else if (nib[1] != Pre9 && nib[1] != Pre6) begin
      s1_nxt.status = ST_PREAMBLE;
    end else if (csum != nib[12]) begin
      s1_nxt.status = ST_CHECKSUM;
    end else if (masked == KHum && raw == '0) begin
      s1_nxt.status = ST_HUMIDITY;
    end else begin
      s1_nxt.status    = ST_OK;
      s1_nxt.model_b   = (nib[1] == Pre6);
      s1_nxt.sensor_id = {nib[3], nib[4]};
      s1_nxt.signature = {first20, nib[12]};
      unique case (masked)
        KTemp: begin
          s1_nxt.kind        = KIND_TEMP;
          s1_nxt.temperature = 12'(dsum) - (model9 ? TempOff9 : TempOff6);
        end
        KHum: begin
          s1_nxt.kind     = KIND_HUM;
          s1_nxt.humidity = raw;
        end
        KRain: begin
          s1_nxt.kind = KIND_RAIN;
          s1_nxt.rain = {nib[7], nib[8], nib[9]};
        end
        KSpeed: begin
          s1_nxt.kind      = KIND_SPEED;
          s1_nxt.direction = nib[9];
          s1_nxt.prod      = 14'(raw) * WindMul;
          s1_nxt.div       = model9 ? DIV_HUNDRED : DIV_TEN;
        end
        KGust: begin
          s1_nxt.kind      = KIND_GUST;
          s1_nxt.direction = nib[9];
          s1_nxt.prod      = 14'(raw) * WindMul;
          s1_nxt.div       = model9 ? DIV_TEN : DIV_ONE;
        end
        default: s1_nxt.kind = KIND_UNKNOWN;
      endcase
    end
  end

  // stage 2: scale the wind value by reciprocal multiply
  assign q10  = (RecipW'(s1_r.prod) * RecipW'(Recip10)) >> RecipShift;
  assign q100 = (RecipW'(s1_r.prod) * RecipW'(Recip100)) >> RecipShift;

  always_comb begin
    out_nxt.status      = s1_r.status;
    out_nxt.kind        = s1_r.kind;
    out_nxt.model_b     = s1_r.model_b;
    out_nxt.sensor_id   = s1_r.sensor_id;
    out_nxt.temperature = s1_r.temperature;
    out_nxt.humidity    = s1_r.humidity;
    out_nxt.rain        = s1_r.rain;
    out_nxt.direction   = s1_r.direction;
    out_nxt.signature   = s1_r.signature;
    unique case (s1_r.div)
      DIV_ONE:     out_nxt.wind = s1_r.prod;
      DIV_TEN:     out_nxt.wind = q10[13:0];
      DIV_HUNDRED: out_nxt.wind = q100[13:0];
      default:     out_nxt.wind = s1_r.prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= q_nonempty;
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = out_r.status;
  assign out_reading_kind   = out_r.kind;
  assign out_model_b        = out_r.model_b;
  assign out_sensor_id      = out_r.sensor_id;
  assign out_temperature    = out_r.temperature;
  assign out_humidity_pct   = out_r.humidity;
  assign out_rain_count     = out_r.rain;
  assign out_wind_direction = out_r.direction;
  assign out_wind_value     = out_r.wind;
  assign out_signature      = out_r.signature;

endmodule

// File: rtl/weather_sensor_pulse_decoder.sv
// channel  | direction | handshake        | payload
// cfg      | in        | cfg_wr_en        | cfg_addr, cfg_wdata
// in       | in        | in_valid/in_stall| mark, space, last pair
// out      | out       | out_valid/stall  | status and decoded fields
//
// one pulse pair is taken every cycle; the front stalls only while the
// two-entry burst queue is full
// a burst result is written into the burst queue and then passes through
// the two register stages of the decode pipeline
// out_stall holds the decode pipeline; the queue keeps the front running
// synchronous active-low reset restores register defaults and empties all
module weather_sensor_pulse_decoder
  import wspd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [DataW-1:0]    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [DataW-1:0]    in_mark_time,
  input  logic [DataW-1:0]    in_space_time,
  input  logic                in_last_pair,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [2:0]          out_reading_kind,
  output logic                out_model_b,
  output logic [7:0]          out_sensor_id,
  output logic signed [11:0]  out_temperature,
  output logic [7:0]          out_humidity_pct,
  output logic [11:0]         out_rain_count,
  output logic [3:0]          out_wind_direction,
  output logic [13:0]         out_wind_value,
  output logic [23:0]         out_signature
);

  logic   q_full, q_push, q_pop, q_nonempty;
  burst_t q_push_data, q_head;

  wspd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mark_time  (in_mark_time),
    .in_space_time (in_space_time),
    .in_last_pair  (in_last_pair),
    .q_full        (q_full),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  wspd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  wspd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_nonempty         (q_nonempty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_reading_kind   (out_reading_kind),
    .out_model_b        (out_model_b),
    .out_sensor_id      (out_sensor_id),
    .out_temperature    (out_temperature),
    .out_humidity_pct   (out_humidity_pct),
    .out_rain_count     (out_rain_count),
    .out_wind_direction (out_wind_direction),
    .out_wind_value     (out_wind_value),
    .out_signature      (out_signature)
  );

endmodule

// File: rtl/wspd_checker.sv
module wspd_checker
  import wspd_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [2:0]          out_status,
  input logic [2:0]          out_reading_kind,
  input logic                out_model_b,
  input logic [7:0]          out_sensor_id,
  input logic signed [11:0]  out_temperature,
  input logic [7:0]          out_humidity_pct,
  input logic [3:0]          out_wind_direction,
  input logic [13:0]         out_wind_value,
  input logic [23:0]         out_signature
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_signature))
    else $error("stalled result dropped or changed");

  // failed burst carries status only
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_reading_kind == '0 && out_sensor_id == '0 && out_signature == '0 &&
      out_wind_value == '0 && out_temperature == '0 && !out_model_b)
    else $error("failed burst with payload");

  // wind fields only for wind readings
  a_wind_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reading_kind != KIND_SPEED && out_reading_kind != KIND_GUST |->
      out_wind_value == '0 && out_wind_direction == '0)
    else $error("wind fields on non-wind reading");

  // good humidity reading is never zero
  a_hum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && out_reading_kind == KIND_HUM |->
      out_humidity_pct != '0)
    else $error("zero humidity reported as ok");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("activity after reset");

endmodule

bind weather_sensor_pulse_decoder wspd_checker u_wspd_checker (.*);

// File: test/tb_weather_sensor_pulse_decoder.sv
module tb_weather_sensor_pulse_decoder
  import wspd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [DataW-1:0] mark;
    logic [DataW-1:0] space;
    logic             last;
  } pulse_pair_t;

  typedef struct {
    status_t            status;
    kind_t              kind;
    logic               model_b;
    logic [7:0]         sensor_id;
    logic signed [11:0] temperature;
    logic [7:0]         humidity;
    logic [11:0]        rain;
    logic [3:0]         wind_dir;
    logic [13:0]        wind_value;
    logic [23:0]        signature;
  } sensor_reading_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                cfg_wr_en     = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr      = '0;
  logic [DataW-1:0]    cfg_wdata     = '0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [DataW-1:0]    in_mark_time  = '0;
  logic [DataW-1:0]    in_space_time = '0;
  logic                in_last_pair  = 1'b0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [2:0]          out_status;
  logic [2:0]          out_reading_kind;
  logic                out_model_b;
  logic [7:0]          out_sensor_id;
  logic signed [11:0]  out_temperature;
  logic [7:0]          out_humidity_pct;
  logic [11:0]         out_rain_count;
  logic [3:0]          out_wind_direction;
  logic [13:0]         out_wind_value;
  logic [23:0]         out_signature;

  // register mirror and burst state of the predictor
  logic [DataW-1:0] space_lo       = SpaceMinRst;
  logic [DataW-1:0] space_hi       = SpaceMaxRst;
  logic [DataW-1:0] mark_threshold = MarkSplitRst;
  logic [BitsW-1:0] shadow_bits       = '0;
  int               shadow_pairs      = 0;
  logic             shadow_timing_bad = 1'b0;

  pulse_pair_t     pair_queue[$];
  sensor_reading_t expected_readings[$];
  pulse_pair_t     current_pair;
  int              pairs_queued  = 0;
  int              pairs_taken   = 0;
  int              bursts_queued = 0;
  int              fail_count    = 0;
  int              send_gap_pct  = 0;
  int              stall_pct     = 0;

  weather_sensor_pulse_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mark_time      (in_mark_time),
    .in_space_time     (in_space_time),
    .in_last_pair      (in_last_pair),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_reading_kind  (out_reading_kind),
    .out_model_b       (out_model_b),
    .out_sensor_id     (out_sensor_id),
    .out_temperature   (out_temperature),
    .out_humidity_pct  (out_humidity_pct),
    .out_rain_count    (out_rain_count),
    .out_wind_direction(out_wind_direction),
    .out_wind_value    (out_wind_value),
    .out_signature     (out_signature)
  );

  always #5ns clk = ~clk;

  function automatic sensor_reading_t decode_telegram(logic [BitsW-1:0] raw_bits, int pairs,
                                                      logic timing_bad);
    sensor_reading_t r;
    logic [BitsW-1:0] bits;
    logic [3:0]       n[NibCnt];
    logic [19:0]      head;
    logic [3:0]       sum;
    int               i;
    int               raw;
    int               temp;
    int               wind;
    r.status      = ST_OK;
    r.kind        = KIND_TEMP;
    r.model_b     = 1'b0;
    r.sensor_id   = '0;
    r.temperature = '0;
    r.humidity    = '0;
    r.rain        = '0;
    r.wind_dir    = '0;
    r.wind_value  = '0;
    r.signature   = '0;
    if (pairs != 52 && pairs != 51) begin
      r.status = ST_COUNT;
      return r;
    end
    if (timing_bad) begin
      r.status = ST_TIMING;
      return r;
    end
    bits = raw_bits;
    // a 51-pair burst lost its final zero bit
    if (pairs == 51) bits = {raw_bits[BitsW-2:0], 1'b0};
    head = bits[51:32];
    sum  = '0;
    for (i = 0; i < NibCnt; i++) n[i] = bits[51-4*i -: 4];
    for (i = 0; i < 12; i++) sum = sum + n[i];
    if (head == '0) begin
      r.status = ST_HEADER;
      return r;
    end
    if (n[0] != SyncNib) begin
      r.status = ST_SYNC;
      return r;
    end
    if (n[1] != Pre9 && n[1] != Pre6) begin
      r.status = ST_PREAMBLE;
      return r;
    end
    if (sum != n[12]) begin
      r.status = ST_CHECKSUM;
      return r;
    end
    raw = {n[7], n[8]};
    case (n[2] & KindMask)
      KTemp: begin
        temp = int'(n[7]) * 100 + int'(n[8]) * 10 + int'(n[9]);
        temp = temp - ((n[1] == Pre9) ? 300 : 400);
        r.kind        = KIND_TEMP;
        r.temperature = temp[11:0];
      end
      KHum: begin
        if (raw == 0) begin
          r.status = ST_HUMIDITY;
          return r;
        end
        r.kind     = KIND_HUM;
        r.humidity = raw[7:0];
      end
      KRain: begin
        r.kind = KIND_RAIN;
        r.rain = {n[7], n[8], n[9]};
      end
      KSpeed, KGust: begin
        wind = (n[2] & KindMask) == KGust ? raw * 36 : raw * 36 / 10;
        if (n[1] == Pre9) wind = wind / 10;
        r.kind       = ((n[2] & KindMask) == KGust) ? KIND_GUST : KIND_SPEED;
        r.wind_dir   = n[9];
        r.wind_value = wind[13:0];
      end
      default: r.kind = KIND_UNKNOWN;
    endcase
    r.model_b   = (n[1] == Pre6);
    r.sensor_id = {n[3], n[4]};
    r.signature = {head, n[12]};
    return r;
  endfunction

  task automatic take_pair(pulse_pair_t p);
    logic bit_val;
    int   total;
    bit_val = (p.mark > mark_threshold) ? 1'b0 : 1'b1;
    if (!p.last && (p.space < space_lo || p.space > space_hi)) shadow_timing_bad = 1'b1;
    shadow_bits = {shadow_bits[BitsW-2:0], bit_val};
    total = shadow_pairs + 1;
    if (shadow_pairs < 127) shadow_pairs++;
    if (p.last) begin
      expected_readings.push_back(decode_telegram(shadow_bits, total, shadow_timing_bad));
      shadow_bits       = '0;
      shadow_pairs      = 0;
      shadow_timing_bad = 1'b0;
    end
  endtask

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_pair(current_pair);
        pairs_taken++;
      end
      // payload may only move when nothing is held
      if (!in_valid || !in_stall) begin
        if (pair_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          current_pair = pair_queue.pop_front();
          in_valid      <= 1'b1;
          in_mark_time  <= current_pair.mark;
          in_space_time <= current_pair.space;
          in_last_pair  <= current_pair.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    sensor_reading_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("reading with none outstanding, status %0d", out_status);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("status", want.status, out_status);
          check_field("reading_kind", want.kind, out_reading_kind);
          check_field("model_b", want.model_b, out_model_b);
          check_field("sensor_id", want.sensor_id, out_sensor_id);
          check_field("temperature", want.temperature, out_temperature);
          check_field("humidity_pct", want.humidity, out_humidity_pct);
          check_field("rain_count", want.rain, out_rain_count);
          check_field("wind_direction", want.wind_dir, out_wind_direction);
          check_field("wind_value", want.wind_value, out_wind_value);
          check_field("signature", want.signature, out_signature);
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic [BitsW-1:0] seal_frame(logic [BitsW-1:0] f);
    logic [3:0] sum;
    int         i;
    sum = '0;
    for (i = 0; i < 12; i++) sum = sum + f[51-4*i -: 4];
    f[3:0] = sum;
    return f;
  endfunction

  function automatic logic [BitsW-1:0] make_frame(logic [3:0] pre, logic [3:0] kind_nib,
                                                  logic [3:0] n7, logic [3:0] n8,
                                                  logic [3:0] n9);
    logic [63:0]      r;
    logic [BitsW-1:0] f;
    r = {$urandom, $urandom};
    f = r[BitsW-1:0];
    f[51:48] = SyncNib;
    f[47:44] = pre;
    f[43:40] = kind_nib;
    f[23:20] = n7;
    f[19:16] = n8;
    f[15:12] = n9;
    return seal_frame(f);
  endfunction

  // a 51-pair burst only decodes when the dropped last bit is zero
  function automatic logic [BitsW-1:0] even_frame(logic [BitsW-1:0] f);
    if (f[0]) begin
      f[4] = ~f[4];
      f    = seal_frame(f);
    end
    return f;
  endfunction

  function automatic logic [DataW-1:0] pick_mark(logic bit_val);
    int sel;
    sel = $urandom_range(0, 7);
    if (bit_val) begin
      if (sel == 0) return '0;
      if (sel == 1) return mark_threshold;
      return DataW'($urandom_range(0, mark_threshold));
    end
    if (mark_threshold == 16'hFFFF || sel == 0) return 16'hFFFF;
    if (sel == 1) return mark_threshold + 16'd1;
    return DataW'($urandom_range(int'(mark_threshold) + 1, 65535));
  endfunction

  function automatic logic [DataW-1:0] pick_space(logic in_window);
    int sel;
    sel = $urandom_range(0, 7);
    if (in_window && space_lo <= space_hi) begin
      if (sel == 0) return space_lo;
      if (sel == 1) return space_hi;
      return DataW'($urandom_range(space_lo, space_hi));
    end
    if (!in_window && space_lo > 0) return DataW'($urandom_range(0, int'(space_lo) - 1));
    if (!in_window && space_hi < 16'hFFFF) begin
      return DataW'($urandom_range(int'(space_hi) + 1, 65535));
    end
    return DataW'($urandom_range(0, 65535));
  endfunction

  task automatic queue_burst(logic [BitsW-1:0] frame, int pairs, int bad_space_at);
    pulse_pair_t p;
    logic        bit_val;
    int          i;
    for (i = 0; i < pairs; i++) begin
      bit_val = (i < BitsW) ? frame[BitsW-1-i] : logic'($urandom_range(0, 1));
      p.mark  = pick_mark(bit_val);
      p.last  = (i == pairs - 1);
      if (p.last) p.space = ($urandom_range(0, 3) == 0) ? 16'hFFFF : pick_space(1'b0);
      else p.space = pick_space(i != bad_space_at);
      pair_queue.push_back(p);
      pairs_queued++;
    end
    bursts_queued++;
  endtask

  task automatic random_burst();
    logic [63:0]      r;
    logic [BitsW-1:0] f;
    logic [3:0]       pre;
    int               pairs;
    int               sel;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 15) begin
      queue_burst(r[BitsW-1:0], $urandom_range(1, 60), $urandom_range(0, 60));
    end else begin
      pre = r[55:52];
      if ($urandom_range(0, 9) != 0) pre = r[56] ? Pre9 : Pre6;
      f = make_frame(pre, r[63:60], r[59:56], r[11:8], r[7:4]);
      sel = $urandom_range(0, 99);
      pairs = (sel < 75) ? 52 : (sel < 90) ? 51 : $urandom_range(40, 60);
      if (pairs == 51) f = even_frame(f);
      // occasional damage to an otherwise good telegram
      case ($urandom_range(0, 19))
        0: f[51:48] = r[3:0] | 4'h1;
        1: f[3:0] = f[3:0] ^ (r[3:0] | 4'h1);
        2: f[51:32] = '0;
        default: ;
      endcase
      queue_burst(f, pairs, ($urandom_range(0, 9) == 0) ? $urandom_range(0, pairs - 1) : -1);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pairs_taken != pairs_queued || expected_readings.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_regs(logic [DataW-1:0] lo, logic [DataW-1:0] hi,
                            logic [DataW-1:0] split);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_SPACE_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr  <= REG_SPACE_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_addr  <= REG_MARK_SPLIT;
    cfg_wdata <= split;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    space_lo       = lo;
    space_hi       = hi;
    mark_threshold = split;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [BitsW-1:0] f;
    int               phase;
    int               start_pairs;
    int               start_bursts;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed telegrams with reset register values, each drained before the next
    queue_burst(make_frame(Pre9, KTemp, 4'h0, 4'h0, 4'h0), 52, -1);
    wait_drained();
    queue_burst(make_frame(Pre6, KGust, 4'hF, 4'hF, 4'hF), 52, -1);
    wait_drained();
    queue_burst(make_frame(Pre6, KHum, 4'h0, 4'h0, 4'h3), 52, -1);
    wait_drained();
    queue_burst(even_frame(make_frame(Pre9, KSpeed, 4'hF, 4'hF, 4'h7)), 51, -1);
    wait_drained();
    // wrong pair counts; 180 would wrap onto 52 without saturation
    f = make_frame(Pre9, KTemp, 4'h3, 4'h2, 4'h1);
    queue_burst(f, 1, -1);
    wait_drained();
    queue_burst(f, 180, -1);
    wait_drained();

    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_regs(16'd1100, 16'd1400, 16'd1000);
        1: write_regs(16'd0, 16'hFFFF, 16'd0);
        2: write_regs(16'd500, 16'd900, 16'hFFFE);
        3: write_regs(16'd2000, 16'd2000, 16'd32768);
        4: write_regs(16'hFFFF, 16'd0, 16'd1);
        5: write_regs(16'd0, 16'd0, 16'hFFFF);
        default: write_regs(16'd1100, 16'd1400, 16'd1000);
      endcase
      case (phase % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 56;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 56;
        end
        default: begin
          send_gap_pct = 38;
          stall_pct    = 38;
        end
      endcase
      start_pairs  = pairs_queued;
      start_bursts = bursts_queued;
      // single-pair bursts back to back fill the burst queue
      repeat (4) queue_burst(f, 1, -1);
      while (pairs_queued - start_pairs < 50 || bursts_queued - start_bursts < 5)
        random_burst();
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
